FILE: sv/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the k-way merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int NUM_SOURCES_DEF = 16;
  localparam int VALUE_BITS_DEF  = 32;
  localparam int SRC_BITS        = 4;
  localparam int IN_VALUE_BITS   = 32;
  localparam int OUT_VALUE_BITS  = 32;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_START   = 2'd1,
    KIND_ADVANCE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

FILE: sv/k_way_merge_heap.sv
// ----------------------------------------------------------------------------
// k_way_merge_heap
// Merges ascending source streams through a pending-entry store in one RAM.
//
// Command channel: an item (kind, present, value, source) is taken on a
// rising edge with start high and busy low. A load item writes one pending
// entry and the block stays idle. A start or advance item (advance first
// writes the next value of the last emitted source) scans the live entries
// through the RAM read port, one entry per cycle, keeping the running
// minimum; ties go to the lower source number. The winner's slot is then
// refilled with the last live entry so the store stays packed.
// An empty store gives a done result in the cycle after acceptance. One
// transaction is worked on at a time; busy is high in the scan and finish
// states.
// Results: strobe is high for exactly one cycle with out_value, out_source
// and done_res; the receiver cannot hold them off.
// Reset (rst, synchronous): empties the store and sets the last source to 0.
// RAM contents are not cleared; only entries below the live count are read.
// ----------------------------------------------------------------------------
module k_way_merge_heap
  import kwm_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       kind,
  input  logic                             present,
  input  logic signed [IN_VALUE_BITS-1:0]  value,
  input  logic [SRC_BITS-1:0]              source,
  output logic                             strobe,
  output logic signed [OUT_VALUE_BITS-1:0] out_value,
  output logic [SRC_BITS-1:0]              out_source,
  output logic                             done_res
);

  localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CW = $clog2(NUM_SOURCES + 1);
  localparam int EW = VALUE_BITS + SRC_BITS;

  // entry layout: {source, value}
  logic [EW-1:0] mem [NUM_SOURCES];
  logic [EW-1:0] rdata;

  state_t state, state_next;

  logic [CW-1:0]         count;
  logic [SRC_BITS-1:0]   last_source;
  logic [CW-1:0]         ridx;
  logic [AW-1:0]         pidx;
  logic                  pvalid;
  logic [VALUE_BITS-1:0] best_val;
  logic [SRC_BITS-1:0]   best_src;
  logic [AW-1:0]         best_idx;
  logic [EW-1:0]         tail;

  kind_t                 kind_in;
  logic                  acc;
  logic                  do_ins;
  logic                  do_pop;
  logic [CW-1:0]         cnt_eff;
  logic [63:0]           v64;
  logic [VALUE_BITS-1:0] v_fit;
  logic [SRC_BITS-1:0]   ins_src;
  logic                  rd_en;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  logic [AW-1:0]         last_idx;
  logic                  last_hit;
  logic [VALUE_BITS-1:0] cand_val;
  logic [SRC_BITS-1:0]   cand_src;
  logic                  cand_take;
  logic [63:0]           ov64;

  assign busy    = (state != ST_IDLE);
  assign acc     = start && !busy;
  assign kind_in = kind_t'(kind);

  // sign-extend the port value, then fit it to the stored width
  assign v64     = 64'(value);
  assign v_fit   = v64[VALUE_BITS-1:0];
  assign ins_src = (kind_in == KIND_LOAD) ? source : last_source;

  assign do_ins  = acc && present && (kind_in == KIND_LOAD || kind_in == KIND_ADVANCE)
                   && (count < CW'(NUM_SOURCES));
  assign do_pop  = acc && (kind_in == KIND_START || kind_in == KIND_ADVANCE);
  assign cnt_eff = count + CW'(do_ins);

  assign last_idx = AW'(count - CW'(1));
  assign last_hit = pvalid && (pidx == last_idx);
  assign rd_en    = (state == ST_SCAN) && (ridx < count);

  assign cand_val  = rdata[VALUE_BITS-1:0];
  assign cand_src  = rdata[EW-1:VALUE_BITS];
  assign cand_take = (pidx == '0)
                     || ($signed(cand_val) < $signed(best_val))
                     || ((cand_val == best_val) && (cand_src < best_src));

  assign ov64 = 64'(best_val);

  // one write port: insert while idle, slot refill at the end of a pop
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = {ins_src, v_fit};
    if (state == ST_IDLE) begin
      wr_en = do_ins;
    end else if (state == ST_FIN) begin
      wr_en   = (best_idx != last_idx);
      wr_addr = best_idx;
      wr_data = tail;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[ridx[AW-1:0]];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_pop && cnt_eff != '0) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_hit) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      last_source <= '0;
      pvalid      <= 1'b0;
      strobe      <= 1'b0;
      ridx        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          count  <= cnt_eff;
          ridx   <= '0;
          pvalid <= 1'b0;
          strobe <= do_pop && (cnt_eff == '0);
        end
        ST_SCAN: begin
          pvalid <= rd_en;
          strobe <= 1'b0;
          if (rd_en) begin
            ridx <= ridx + CW'(1);
          end
        end
        ST_FIN: begin
          count       <= count - CW'(1);
          last_source <= best_src;
          strobe      <= 1'b1;
          pvalid      <= 1'b0;
        end
        default: begin
          pvalid <= 1'b0;
          strobe <= 1'b0;
        end
      endcase
    end
  end

  // scan datapath and result registers
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      if (rd_en) begin
        pidx <= ridx[AW-1:0];
      end
      if (pvalid) begin
        if (cand_take) begin
          best_val <= cand_val;
          best_src <= cand_src;
          best_idx <= pidx;
        end
        if (last_hit) begin
          tail <= rdata;
        end
      end
    end
    if (state == ST_IDLE && do_pop && cnt_eff == '0) begin
      out_value  <= '0;
      out_source <= '0;
      done_res   <= 1'b1;
    end else if (state == ST_FIN) begin
      out_value  <= ov64[OUT_VALUE_BITS-1:0];
      out_source <= best_src;
      done_res   <= 1'b0;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: k-way merge block testbench
// Drives load, start and advance commands into k_way_merge_heap and checks
// every emitted value, source and done flag against an in-bench model of the
// pending store. Stimulus is a short directed run, then mostly well-formed
// merges of ascending streams with random idle gaps, plus noise and broken
// sequences.
// ----------------------------------------------------------------------------
module tb_top;
  import kwm_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int STALL_LIMIT = 400;
  localparam int TAIL_CYCLES = 30;

  typedef struct packed {
    logic signed [OUT_VALUE_BITS-1:0] val;
    logic [SRC_BITS-1:0]              src;
  } pending_t;

  typedef struct packed {
    logic signed [OUT_VALUE_BITS-1:0] val;
    logic [SRC_BITS-1:0]              src;
    logic                             done;
  } merge_result_t;

  // Scoreboard: mirrors the pending store and queues the merged output.
  class merge_checker;
    pending_t            slots [NUM_SOURCES_DEF];
    int unsigned         live;
    logic [SRC_BITS-1:0] last_src;
    bit                  last_done;
    merge_result_t       merged_q [$];
    int                  errors;
    int unsigned         effective_items;

    function new();
      live = 0;
      last_src = '0;
      last_done = 1'b0;
      errors = 0;
      effective_items = 0;
    endfunction

    function void add_pending(logic signed [OUT_VALUE_BITS-1:0] v, logic [SRC_BITS-1:0] s);
      if (live >= NUM_SOURCES_DEF) return;  // full store drops the insert
      slots[live].val = v;
      slots[live].src = s;
      live++;
    endfunction

    function void pop_minimum();
      merge_result_t r;
      int best;
      if (live == 0) begin
        r.val = '0;
        r.src = '0;
        r.done = 1'b1;
        merged_q.push_back(r);
        last_done = 1'b1;
        return;
      end
      best = 0;
      for (int i = 1; i < live; i++) begin
        if ($signed(slots[i].val) < $signed(slots[best].val) ||
            (slots[i].val == slots[best].val && slots[i].src < slots[best].src))
          best = i;
      end
      r.val = slots[best].val;
      r.src = slots[best].src;
      r.done = 1'b0;
      merged_q.push_back(r);
      last_src = slots[best].src;
      last_done = 1'b0;
      live--;
      if (best != live) slots[best] = slots[live];  // keep the store packed
    endfunction

    function void note_item(kind_t k, bit p, logic signed [IN_VALUE_BITS-1:0] v,
                            logic [SRC_BITS-1:0] s);
      case (k)
        KIND_LOAD: begin
          if (p && live < NUM_SOURCES_DEF) effective_items++;
          if (p) add_pending(v, s);
        end
        KIND_START: begin
          effective_items++;
          pop_minimum();
        end
        KIND_ADVANCE: begin
          effective_items++;
          if (p) add_pending(v, last_src);
          pop_minimum();
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [OUT_VALUE_BITS-1:0] v, logic [SRC_BITS-1:0] s,
                               logic d);
      merge_result_t e;
      if (merged_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d source %0d done %0b",
                 $time, v, s, d);
        errors++;
        return;
      end
      e = merged_q.pop_front();
      if (v !== e.val) begin
        $display("%0t: out_value expected %0d actual %0d", $time, $signed(e.val), v);
        errors++;
      end
      if (s !== e.src) begin
        $display("%0t: out_source expected %0d actual %0d", $time, e.src, s);
        errors++;
      end
      if (d !== e.done) begin
        $display("%0t: done_res expected %0b actual %0b", $time, e.done, d);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             start;
  logic                             busy;
  logic [1:0]                       kind;
  logic                             present;
  logic signed [IN_VALUE_BITS-1:0]  value;
  logic [SRC_BITS-1:0]              source;
  logic                             strobe;
  logic signed [OUT_VALUE_BITS-1:0] out_value;
  logic [SRC_BITS-1:0]              out_source;
  logic                             done_res;

  merge_checker chk = new();
  bit           back_to_back;
  int           idle_cycles;

  k_way_merge_heap dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .present    (present),
    .value      (value),
    .source     (source),
    .strobe     (strobe),
    .out_value  (out_value),
    .out_source (out_source),
    .done_res   (done_res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result check and stall watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (strobe) chk.check_result(out_value, out_source, done_res);
      if (strobe || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // One command transaction: optional idle gap with junk fields, then hold
  // start until the block takes it.
  task automatic issue(kind_t k, bit p, logic signed [IN_VALUE_BITS-1:0] v,
                       logic [SRC_BITS-1:0] s);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        kind <= 2'($urandom);
        present <= 1'($urandom);
        value <= $urandom;
        source <= 4'($urandom);
        @(negedge clk);
      end
    end
    start <= 1'b1;
    kind <= k;
    present <= p;
    value <= v;
    source <= s;
    do @(posedge clk); while (busy);
    chk.note_item(k, p, v, s);
  endtask

  task automatic run_directed();
    logic signed [31:0] head_val [8] = '{32'sd0, 32'sd0, 32'sh7fff_ffff, 32'sh8000_0000,
                                         -32'sd1, 32'sd100, 32'sd100, 32'sd50};
    logic [3:0]         head_src [8] = '{4'd3, 4'd1, 4'd0, 4'd15, 4'd2, 4'd7, 4'd7, 4'd7};
    logic [3:0]         fill_src [8] = '{4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12};
    back_to_back = 1'b0;
    issue(KIND_START, 1'b0, '0, '0);                      // empty store: done
    issue(KIND_ADVANCE, 1'b0, $urandom, 4'($urandom));    // empty store: done
    issue(KIND_ADVANCE, 1'b1, 32'sd5, 4'd9);              // inserts under source 0
    issue(KIND_NONE, 1'b1, $urandom, 4'($urandom));
    issue(KIND_LOAD, 1'b0, -32'sd7, 4'd3);                // empty source, nothing stored
    // ties, both extremes and a repeated source; then fill to capacity
    for (int i = 0; i < 8; i++) issue(KIND_LOAD, 1'b1, head_val[i], head_src[i]);
    for (int i = 0; i < 8; i++) issue(KIND_LOAD, 1'b1, $urandom, fill_src[i]);
    issue(KIND_LOAD, 1'b1, 32'sh8000_0000, 4'd14);        // full: dropped
    issue(KIND_ADVANCE, 1'b1, 32'sh8000_0000, 4'd0);      // full: insert dropped, pop only
    issue(KIND_START, 1'b0, $urandom, 4'($urandom));
    issue(KIND_START, 1'b0, $urandom, 4'($urandom));
  endtask

  // One well-formed merge of ascending streams, with the odd broken item.
  task automatic run_merge();
    int         streams [16][$];
    int         picks [16];
    int         nsrc;
    int         len;
    int         j;
    int         t;
    bit         ties;
    logic [3:0] s;
    while (chk.live > 0) issue(KIND_START, 1'b0, $urandom, 4'($urandom));
    for (int i = 0; i < 16; i++) picks[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = picks[i];
      picks[i] = picks[j];
      picks[j] = t;
    end
    nsrc = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    ties = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < nsrc; i++) begin
      len = $urandom_range(0, 5);
      repeat (len) begin
        if (ties) streams[picks[i]].push_back(int'($urandom_range(0, 6)) - 3);
        else streams[picks[i]].push_back(int'($urandom));
      end
      streams[picks[i]].sort();
    end
    for (int i = 0; i < nsrc; i++) begin
      s = 4'(picks[i]);
      if (streams[s].size() > 0) issue(KIND_LOAD, 1'b1, streams[s].pop_front(), s);
      else issue(KIND_LOAD, 1'b0, $urandom, s);
    end
    issue(KIND_START, 1'b0, $urandom, 4'($urandom));
    while (!chk.last_done) begin
      if ($urandom_range(0, 49) == 0) begin
        case ($urandom_range(0, 2))
          0: issue(KIND_NONE, 1'($urandom), $urandom, 4'($urandom));
          1: issue(KIND_START, 1'($urandom), $urandom, 4'($urandom));
          default: issue(KIND_LOAD, 1'b1, $urandom, 4'($urandom));
        endcase
      end else begin
        s = chk.last_src;
        if (streams[s].size() > 0) issue(KIND_ADVANCE, 1'b1, streams[s].pop_front(), 4'($urandom));
        else issue(KIND_ADVANCE, 1'b0, $urandom, 4'($urandom));
      end
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 8))
      issue(kind_t'($urandom_range(0, 3)), 1'($urandom), $urandom, 4'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_LOAD;
    present = 1'b0;
    value = '0;
    source = '0;
    back_to_back = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    while (chk.effective_items < ITEM_TARGET) begin
      back_to_back = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) run_noise();
      else run_merge();
    end
    @(negedge clk);
    start <= 1'b0;
    while (chk.merged_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (chk.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
